// ----- hw/rtl/arc_pkg.sv -----
// Shared types, codes and constants of the ARP resolution cache.
package arc_pkg;

   localparam int CACHE_ENTRIES_DEF = 16;
   localparam int REQUEST_ENTRIES_DEF = 16;
   localparam int HELD_ENTRIES_DEF = 16;

   localparam int MAX_RESULTS = 16;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   localparam int MAC_W = 48;
   localparam int IP_W = 32;
   localparam int TMR_W = 20;
   localparam int HDL_W = 16;
   localparam int ETYPE_W = 16;
   localparam int OPCODE_W = 16;
   localparam int CMD_W = 2;
   localparam int KIND_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam int REQ_TDATA_W = 312;
   localparam int RSP_TDATA_W = 144;

   localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;
   localparam logic [ETYPE_W-1:0] ETYPE_ARP = 16'h0806;
   localparam logic [OPCODE_W-1:0] ARP_OP_REQUEST = 16'd1;
   localparam logic [OPCODE_W-1:0] ARP_OP_REPLY = 16'd2;
   localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};
   localparam logic [TMR_W-1:0] LIFETIME_RESET = 20'd30000;
   localparam logic [TMR_W-1:0] HOLD_RESET = 20'd5000;

   typedef enum logic [CMD_W-1:0] {
      CMD_SEND = 2'd0,
      CMD_RECV = 2'd1,
      CMD_TICK = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_IPV4_OUT = 3'd0,
      KIND_ARP_REQ = 3'd1,
      KIND_ARP_REPLY = 3'd2,
      KIND_DELIVER = 3'd3,
      KIND_DROP = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_MAC = 2'd0,
      CSR_OWN_IP = 2'd1,
      CSR_CACHE_LIFE = 2'd2,
      CSR_REQ_HOLD = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEND_CACHE,
      ST_SEND_HELD,
      ST_SEND_REQ,
      ST_LEARN,
      ST_FLUSH,
      ST_AGE_CACHE,
      ST_AGE_REQ,
      ST_FINISH
   } fsm_state_type;

   typedef struct packed {
      kind_type kind;
      logic [MAC_W-1:0] dest_mac;
      logic [MAC_W-1:0] target_mac;
      logic [IP_W-1:0] target_addr;
      logic [HDL_W-1:0] handle;
   } result_type;

   typedef struct packed {
      logic [IP_W-1:0] ent_ip;
      logic [IP_W-1:0] key;
      logic [TMR_W-1:0] ent_timer;
      logic [TMR_W-1:0] ref_timer;
      logic [TMR_W-1:0] ms;
   } scan_in_type;

   typedef struct packed {
      logic ip_eq;
      logic timer_lt;
      logic [TMR_W-1:0] aged;
      logic aged_zero;
   } scan_out_type;

   typedef struct packed {
      logic push;
      logic fin;
   } stage_ctl_type;

   typedef struct packed {
      logic stall;
      logic pend_valid;
   } stage_sts_type;

endpackage

// ----- hw/rtl/arc_scan_unit.sv -----
// Shared compare and saturating subtract unit used by the table scans.
module arc_scan_unit (
   input  arc_pkg::scan_in_type  scan_in,
   output arc_pkg::scan_out_type scan_out
);
   import arc_pkg::*;

   logic gt_ms;

   always_comb begin
      gt_ms = scan_in.ent_timer > scan_in.ms;
      scan_out.ip_eq = scan_in.ent_ip == scan_in.key;
      scan_out.timer_lt = scan_in.ent_timer < scan_in.ref_timer;
      scan_out.aged = gt_ms ? (scan_in.ent_timer - scan_in.ms) : '0;
      scan_out.aged_zero = !gt_ms;
   end

endmodule

// ----- hw/rtl/arc_out_stage.sv -----
// Result staging: a pending slot that learns the last flag, then the output register.
module arc_out_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  arc_pkg::stage_ctl_type           ctl,
   input  arc_pkg::result_type              res,
   output arc_pkg::stage_sts_type           sts,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // dest_mac, arp_target_mac, arp_target_addr, out_handle (lowest bit up)
   output logic [arc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // result_kind
   output logic [arc_pkg::KIND_W-1:0]       rsp_tuser,
   // last_result
   output logic                             rsp_tlast
);
   import arc_pkg::*;

   logic pend_valid_ff, pend_valid_in;
   result_type pend_ff;
   logic out_valid_ff, out_valid_in;
   result_type out_ff;
   logic out_last_ff;
   logic out_free, stall, load;

   always_comb begin
      out_free = !out_valid_ff || rsp_tready;
      stall = pend_valid_ff && !out_free && (ctl.push || ctl.fin);
      load = !stall && pend_valid_ff && (ctl.push || ctl.fin);
      out_valid_in = load || (out_valid_ff && !rsp_tready);
      pend_valid_in = pend_valid_ff;
      if (!stall) begin
         if (ctl.push) begin
            pend_valid_in = 1'b1;
         end else if (ctl.fin) begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= pend_ff;
         out_last_ff <= ctl.fin;
      end
      if (ctl.push && !stall) begin
         pend_ff <= res;
      end
   end

   assign sts.stall = stall;
   assign sts.pend_valid = pend_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {out_ff.handle, out_ff.target_addr, out_ff.target_mac, out_ff.dest_mac};
   assign rsp_tuser = out_ff.kind;
   assign rsp_tlast = out_last_ff;

endmodule

// ----- hw/rtl/arp_resolver_with_timed_cache_core.sv -----
// Top level of the ARP resolution engine: sequencer, tables and configuration.
// A send scans the cache, on a miss the held store, then with a free slot the requests;
// a tick ages the cache, then the requests; a learning receive scans the cache; a reply
// flush adds a held scan per flushed datagram plus an empty one if fewer than 16 go out.
// Throughput: one transaction at a time; req_tready is high only in the idle state, the
// entry-per-cycle scans set the rate, and a stalled result path adds its stall cycles.
// Reset: synchronous; clears all valid bits at once, so no clearing pass is needed.
module arp_resolver_with_timed_cache_core #(
   parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = arc_pkg::REQUEST_ENTRIES_DEF,
   parameter int HELD_ENTRIES = arc_pkg::HELD_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // next_hop_ip, datagram_handle, frame_dst_mac, frame_src_mac, frame_ether_type,
   // payload_ok, arp_opcode, arp_sender_mac, arp_sender_ip, arp_target_ip,
   // elapsed_ms (lowest bit up)
   input  logic [arc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // command
   input  logic [arc_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // dest_mac, arp_target_mac, arp_target_addr, out_handle (lowest bit up)
   output logic [arc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // result_kind
   output logic [arc_pkg::KIND_W-1:0]       rsp_tuser,
   // last_result
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [arc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arc_pkg::MAC_W-1:0]        csr_wdata
);
   import arc_pkg::*;

   localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int RIW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
   localparam int HIW = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;
   localparam int SIW_CR = (CIW > RIW) ? CIW : RIW;
   localparam int SIW = (SIW_CR > HIW) ? SIW_CR : HIW;
   localparam int OW = HIW;
   localparam int HCW = $clog2(HELD_ENTRIES + 1);

   // Configuration registers.
   logic [MAC_W-1:0] own_mac_ff;
   logic [IP_W-1:0] own_ip_ff;
   logic [TMR_W-1:0] life_ff;
   logic [TMR_W-1:0] hold_ff;

   // Latched transaction fields.
   cmd_type cmd_ff;
   logic [IP_W-1:0] hop_ff;
   logic [HDL_W-1:0] handle_ff;
   logic [MAC_W-1:0] dst_ff, src_ff, smac_ff;
   logic [ETYPE_W-1:0] etype_ff;
   logic ok_ff;
   logic [OPCODE_W-1:0] opcode_ff;
   logic [IP_W-1:0] sip_ff, tip_ff;
   logic [TMR_W-1:0] ms_ff;

   // Tables.
   logic cache_valid_ff [CACHE_ENTRIES];
   logic [IP_W-1:0] cache_ip_ff [CACHE_ENTRIES];
   logic [MAC_W-1:0] cache_mac_ff [CACHE_ENTRIES];
   logic [TMR_W-1:0] cache_timer_ff [CACHE_ENTRIES];
   logic request_valid_ff [REQUEST_ENTRIES];
   logic [IP_W-1:0] request_ip_ff [REQUEST_ENTRIES];
   logic [TMR_W-1:0] request_timer_ff [REQUEST_ENTRIES];
   logic held_valid_ff [HELD_ENTRIES];
   logic [IP_W-1:0] held_hop_ip_ff [HELD_ENTRIES];
   logic [HDL_W-1:0] held_handle_ff [HELD_ENTRIES];
   logic [OW-1:0] held_order_ff [HELD_ENTRIES];

   // Sequencer and scan state.
   fsm_state_type state_ff, state_in;
   logic [SIW-1:0] idx_ff, idx_in;
   logic match_fnd_ff, match_fnd_in;
   logic [SIW-1:0] match_idx_ff, match_idx_in;
   logic free_fnd_ff, free_fnd_in;
   logic [SIW-1:0] free_idx_ff, free_idx_in;
   logic [SIW-1:0] best_idx_ff, best_idx_in;
   logic [TMR_W-1:0] best_tmr_ff, best_tmr_in;
   logic [HCW-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [SIW-1:0] slot_n;

   logic [CIW-1:0] ci;
   logic [RIW-1:0] ri;
   logic [HIW-1:0] hi;
   logic cur_valid, cur_match, last_idx, restart, accept, scanning, flush_again;
   logic rx_filter, rx_deliver, rx_arp;

   scan_in_type scan_in;
   scan_out_type scan_out;
   stage_ctl_type stage_ctl;
   stage_sts_type stage_sts;
   result_type res;
   logic stall;

   // Actions of the current cycle.
   logic cache_wr, req_wr, held_wr, flush_rm, age_c, age_r;

   assign ci = idx_ff[CIW-1:0];
   assign ri = idx_ff[RIW-1:0];
   assign hi = idx_ff[HIW-1:0];
   assign req_tready = state_ff == ST_IDLE;
   assign accept = req_tvalid && req_tready;
   assign stall = stage_sts.stall;

   arc_scan_unit u_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   arc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (stage_ctl),
      .res        (res),
      .sts        (stage_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Receive classification from the latched frame.
   always_comb begin
      rx_filter = (dst_ff == own_mac_ff) || (dst_ff == BCAST_MAC);
      rx_deliver = rx_filter && (etype_ff == ETYPE_IPV4) && ok_ff;
      rx_arp = rx_filter && (etype_ff == ETYPE_ARP) && ok_ff && (tip_ff == own_ip_ff);
   end

   // Operand selection for the shared unit and the scan bookkeeping.
   always_comb begin
      scan_in = '0;
      cur_valid = 1'b0;
      last_idx = 1'b0;
      scanning = 1'b1;
      case (state_ff)
         ST_SEND_CACHE: begin
            scan_in.ent_ip = cache_ip_ff[ci];
            scan_in.key = hop_ff;
            cur_valid = cache_valid_ff[ci];
            last_idx = idx_ff == SIW'(CACHE_ENTRIES - 1);
         end
         ST_SEND_HELD: begin
            cur_valid = held_valid_ff[hi];
            last_idx = idx_ff == SIW'(HELD_ENTRIES - 1);
         end
         ST_SEND_REQ: begin
            scan_in.ent_ip = request_ip_ff[ri];
            scan_in.key = hop_ff;
            scan_in.ent_timer = request_timer_ff[ri];
            scan_in.ref_timer = best_tmr_ff;
            cur_valid = request_valid_ff[ri];
            last_idx = idx_ff == SIW'(REQUEST_ENTRIES - 1);
         end
         ST_LEARN: begin
            scan_in.ent_ip = cache_ip_ff[ci];
            scan_in.key = sip_ff;
            scan_in.ent_timer = cache_timer_ff[ci];
            scan_in.ref_timer = best_tmr_ff;
            cur_valid = cache_valid_ff[ci];
            last_idx = idx_ff == SIW'(CACHE_ENTRIES - 1);
         end
         ST_FLUSH: begin
            // Age rank goes through the timer comparator, zero extended.
            scan_in.ent_ip = held_hop_ip_ff[hi];
            scan_in.key = sip_ff;
            scan_in.ent_timer = TMR_W'(held_order_ff[hi]);
            scan_in.ref_timer = best_tmr_ff;
            cur_valid = held_valid_ff[hi];
            last_idx = idx_ff == SIW'(HELD_ENTRIES - 1);
         end
         ST_AGE_CACHE: begin
            scan_in.ent_timer = cache_timer_ff[ci];
            scan_in.ms = ms_ff;
            cur_valid = cache_valid_ff[ci];
            last_idx = idx_ff == SIW'(CACHE_ENTRIES - 1);
         end
         ST_AGE_REQ: begin
            scan_in.ent_timer = request_timer_ff[ri];
            scan_in.ms = ms_ff;
            cur_valid = request_valid_ff[ri];
            last_idx = idx_ff == SIW'(REQUEST_ENTRIES - 1);
         end
         default: begin
            scanning = 1'b0;
         end
      endcase
      cur_match = cur_valid && scan_out.ip_eq;

      match_fnd_in = match_fnd_ff;
      match_idx_in = match_idx_ff;
      free_fnd_in = free_fnd_ff;
      free_idx_in = free_idx_ff;
      best_idx_in = best_idx_ff;
      best_tmr_in = best_tmr_ff;
      count_in = count_ff + HCW'(cur_valid);
      if (state_ff == ST_FLUSH) begin
         // Oldest held datagram for the replying hop.
         if (cur_match && (!match_fnd_ff || scan_out.timer_lt)) begin
            match_fnd_in = 1'b1;
            match_idx_in = idx_ff;
            best_tmr_in = scan_in.ent_timer;
         end
      end else begin
         if (cur_match && !match_fnd_ff) begin
            match_fnd_in = 1'b1;
            match_idx_in = idx_ff;
         end
         if (!cur_valid && !free_fnd_ff) begin
            free_fnd_in = 1'b1;
            free_idx_in = idx_ff;
         end
         // Eviction candidate: smallest remaining time, lowest index on a tie.
         if ((idx_ff == '0) || scan_out.timer_lt) begin
            best_idx_in = idx_ff;
            best_tmr_in = scan_in.ent_timer;
         end
      end
      if (match_fnd_in) begin
         slot_n = match_idx_in;
      end else if (free_fnd_in) begin
         slot_n = free_idx_in;
      end else begin
         slot_n = best_idx_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (cmd_ff)
               CMD_SEND: state_in = ST_SEND_CACHE;
               CMD_RECV: state_in = rx_arp ? ST_LEARN : ST_FINISH;
               CMD_TICK: state_in = ST_AGE_CACHE;
               default: state_in = ST_FINISH;
            endcase
         end
         ST_SEND_CACHE: begin
            if (cur_match) begin
               state_in = ST_FINISH;
            end else if (last_idx) begin
               state_in = ST_SEND_HELD;
            end
         end
         ST_SEND_HELD: begin
            if (last_idx) begin
               state_in = free_fnd_in ? ST_SEND_REQ : ST_FINISH;
            end
         end
         ST_SEND_REQ: begin
            if (last_idx) begin
               state_in = ST_FINISH;
            end
         end
         ST_LEARN: begin
            if (last_idx) begin
               state_in = (opcode_ff == ARP_OP_REPLY) ? ST_FLUSH : ST_FINISH;
            end
         end
         ST_FLUSH: begin
            if (last_idx && !flush_again) begin
               state_in = ST_FINISH;
            end
         end
         ST_AGE_CACHE: begin
            if (last_idx) begin
               state_in = ST_AGE_REQ;
            end
         end
         ST_AGE_REQ: begin
            if (last_idx) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Actions and result formation.
   always_comb begin
      res = '0;
      stage_ctl = '0;
      cache_wr = 1'b0;
      req_wr = 1'b0;
      held_wr = 1'b0;
      flush_rm = 1'b0;
      age_c = 1'b0;
      age_r = 1'b0;
      flush_again = 1'b0;
      case (state_ff)
         ST_DECODE: begin
            if (cmd_ff == CMD_RECV && rx_deliver) begin
               stage_ctl.push = 1'b1;
               res.kind = KIND_DELIVER;
               res.handle = handle_ff;
            end
         end
         ST_SEND_CACHE: begin
            if (cur_match) begin
               stage_ctl.push = 1'b1;
               res.kind = KIND_IPV4_OUT;
               res.dest_mac = cache_mac_ff[ci];
               res.handle = handle_ff;
            end
         end
         ST_SEND_HELD: begin
            if (last_idx) begin
               if (free_fnd_in) begin
                  held_wr = 1'b1;
               end else begin
                  stage_ctl.push = 1'b1;
                  res.kind = KIND_DROP;
                  res.handle = handle_ff;
               end
            end
         end
         ST_SEND_REQ: begin
            if (last_idx && !match_fnd_in) begin
               req_wr = 1'b1;
               stage_ctl.push = 1'b1;
               res.kind = KIND_ARP_REQ;
               res.dest_mac = BCAST_MAC;
               res.target_addr = hop_ff;
            end
         end
         ST_LEARN: begin
            if (last_idx) begin
               cache_wr = 1'b1;
               if (opcode_ff == ARP_OP_REQUEST) begin
                  stage_ctl.push = 1'b1;
                  res.kind = KIND_ARP_REPLY;
                  res.dest_mac = src_ff;
                  res.target_mac = smac_ff;
                  res.target_addr = sip_ff;
               end
            end
         end
         ST_FLUSH: begin
            if (last_idx && match_fnd_in) begin
               flush_rm = 1'b1;
               stage_ctl.push = 1'b1;
               res.kind = KIND_IPV4_OUT;
               res.dest_mac = smac_ff;
               res.handle = held_handle_ff[match_idx_in[HIW-1:0]];
               flush_again = cnt_ff != CNT_W'(MAX_RESULTS - 1);
            end
         end
         ST_AGE_CACHE: age_c = 1'b1;
         ST_AGE_REQ: age_r = 1'b1;
         ST_FINISH: stage_ctl.fin = 1'b1;
         default: begin
         end
      endcase
   end

   assign restart = (state_in != state_ff) || flush_again;
   assign idx_in = (restart || !scanning) ? '0 : idx_ff + SIW'(1);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         match_fnd_ff <= 1'b0;
         free_fnd_ff <= 1'b0;
         count_ff <= '0;
         cnt_ff <= '0;
      end else if (!stall) begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         if (restart) begin
            match_fnd_ff <= 1'b0;
            free_fnd_ff <= 1'b0;
            count_ff <= '0;
         end else begin
            match_fnd_ff <= match_fnd_in;
            free_fnd_ff <= free_fnd_in;
            count_ff <= count_in;
         end
         if (accept) begin
            cnt_ff <= '0;
         end else if (stage_ctl.push) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   // Scan payload registers.
   always_ff @(posedge clock) begin
      if (!stall) begin
         if (restart) begin
            best_tmr_ff <= '0;
         end else begin
            best_tmr_ff <= best_tmr_in;
         end
         match_idx_ff <= match_idx_in;
         free_idx_ff <= free_idx_in;
         best_idx_ff <= best_idx_in;
      end
   end

   // Transaction latch.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_tuser);
         hop_ff <= req_tdata[31:0];
         handle_ff <= req_tdata[47:32];
         dst_ff <= req_tdata[95:48];
         src_ff <= req_tdata[143:96];
         etype_ff <= req_tdata[159:144];
         ok_ff <= req_tdata[160];
         opcode_ff <= req_tdata[176:161];
         smac_ff <= req_tdata[224:177];
         sip_ff <= req_tdata[256:225];
         tip_ff <= req_tdata[288:257];
         ms_ff <= req_tdata[308:289];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_mac_ff <= '0;
         own_ip_ff <= '0;
         life_ff <= LIFETIME_RESET;
         hold_ff <= HOLD_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OWN_MAC: own_mac_ff <= csr_wdata;
            CSR_OWN_IP: own_ip_ff <= csr_wdata[IP_W-1:0];
            CSR_CACHE_LIFE: life_ff <= csr_wdata[TMR_W-1:0];
            CSR_REQ_HOLD: hold_ff <= csr_wdata[TMR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Valid bits; an aged entry that reaches zero drops out.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            cache_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < REQUEST_ENTRIES; i++) begin
            request_valid_ff[i] <= 1'b0;
         end
         for (int i = 0; i < HELD_ENTRIES; i++) begin
            held_valid_ff[i] <= 1'b0;
         end
      end else if (!stall) begin
         if (cache_wr) begin
            cache_valid_ff[slot_n[CIW-1:0]] <= 1'b1;
         end
         if (age_c && cache_valid_ff[ci] && scan_out.aged_zero) begin
            cache_valid_ff[ci] <= 1'b0;
         end
         if (req_wr) begin
            request_valid_ff[slot_n[RIW-1:0]] <= 1'b1;
         end
         if (age_r && request_valid_ff[ri] && scan_out.aged_zero) begin
            request_valid_ff[ri] <= 1'b0;
         end
         if (held_wr) begin
            held_valid_ff[free_idx_in[HIW-1:0]] <= 1'b1;
         end
         if (flush_rm) begin
            held_valid_ff[match_idx_in[HIW-1:0]] <= 1'b0;
         end
      end
   end

   // Table contents.
   always_ff @(posedge clock) begin
      if (!stall) begin
         if (cache_wr) begin
            cache_ip_ff[slot_n[CIW-1:0]] <= sip_ff;
            cache_mac_ff[slot_n[CIW-1:0]] <= smac_ff;
            cache_timer_ff[slot_n[CIW-1:0]] <= life_ff;
         end
         if (age_c && cache_valid_ff[ci]) begin
            cache_timer_ff[ci] <= scan_out.aged;
         end
         if (req_wr) begin
            request_ip_ff[slot_n[RIW-1:0]] <= hop_ff;
            request_timer_ff[slot_n[RIW-1:0]] <= hold_ff;
         end
         if (age_r && request_valid_ff[ri]) begin
            request_timer_ff[ri] <= scan_out.aged;
         end
         if (held_wr) begin
            held_hop_ip_ff[free_idx_in[HIW-1:0]] <= hop_ff;
            held_handle_ff[free_idx_in[HIW-1:0]] <= handle_ff;
            held_order_ff[free_idx_in[HIW-1:0]] <= count_in[OW-1:0];
         end
         if (flush_rm) begin
            // Keep the age ranks compact after removing the flushed datagram.
            for (int i = 0; i < HELD_ENTRIES; i++) begin
               if (held_valid_ff[i] && (held_order_ff[i] > best_tmr_in[OW-1:0])) begin
                  held_order_ff[i] <= held_order_ff[i] - OW'(1);
               end
            end
         end
      end
   end

   // A new transaction must find the result staging empty.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      accept |-> !stage_sts.pend_valid)
      else $error("transaction accepted with a result still pending");

   // One transaction never causes more results than the limit.
   a_result_limit: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result count past the limit");

   // A held datagram only goes into a free slot.
   a_held_free: assert property (@(posedge clock) disable iff (reset)
      (held_wr && !stall) |-> !held_valid_ff[free_idx_in[HIW-1:0]])
      else $error("held datagram overwrote a live entry");

   // Finishing returns the block to accepting transactions.
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !stall) |=> req_tready)
      else $error("sequencer did not return to idle");

endmodule

// ----- tb/arp_resolver_checker.sv -----
// Checker for the ARP resolution cache: predicts each transaction's results and compares.
module arp_resolver_checker
   import arc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tready,
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   input  logic [CMD_W-1:0]        req_tuser,
   input  logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  logic [RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic [KIND_W-1:0]       rsp_tuser,
   input  logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [MAC_W-1:0]        csr_wdata,
   output int                      fail_count,
   output int                      results_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NE = 16;

   typedef struct {
      kind_type          kind;
      logic [MAC_W-1:0]  dmac;
      logic [MAC_W-1:0]  tmac;
      logic [IP_W-1:0]   taddr;
      logic [HDL_W-1:0]  hdl;
      logic              last;
   } outcome_type;

   outcome_type awaited_q[$];

   logic [MAC_W-1:0] my_mac;
   logic [IP_W-1:0]  my_ip;
   logic [TMR_W-1:0] lifetime, hold_time;

   bit               c_ok[NE];
   logic [IP_W-1:0]  c_ip[NE];
   logic [MAC_W-1:0] c_mac[NE];
   logic [TMR_W-1:0] c_tmr[NE];
   bit               r_ok[NE];
   logic [IP_W-1:0]  r_ip[NE];
   logic [TMR_W-1:0] r_tmr[NE];
   bit               h_ok[NE];
   logic [IP_W-1:0]  h_ip[NE];
   logic [HDL_W-1:0] h_hdl[NE];
   // Arrival stamp of each held datagram; the smallest stamp is the oldest.
   int unsigned      h_stamp[NE];
   int unsigned      stamp_next;

   outcome_type burst[$];

   function automatic void add(kind_type k, logic [MAC_W-1:0] d, logic [MAC_W-1:0] t,
                               logic [IP_W-1:0] a, logic [HDL_W-1:0] h);
      outcome_type o;
      if (burst.size() >= MAX_RESULTS) return;
      o.kind = k; o.dmac = d; o.tmac = t; o.taddr = a; o.hdl = h; o.last = 1'b0;
      burst.insert(burst.size(), o);
   endfunction

   // Matching entry first, then the first free one, then the one closest to expiry.
   function automatic int choose_slot(ref bit v[NE], ref logic [IP_W-1:0] ip[NE],
                                      ref logic [TMR_W-1:0] t[NE], input logic [IP_W-1:0] key);
      int best;
      best = 0;
      for (int i = 0; i < NE; i++) if (v[i] && ip[i] == key) return i;
      for (int i = 0; i < NE; i++) if (!v[i]) return i;
      for (int i = 1; i < NE; i++) if (t[i] < t[best]) best = i;
      return best;
   endfunction

   function automatic void resolve_send(logic [IP_W-1:0] hop, logic [HDL_W-1:0] hdl);
      int slot, s;
      bit live;
      slot = -1;
      live = 0;
      for (int i = 0; i < NE; i++) begin
         if (c_ok[i] && c_ip[i] == hop) begin
            add(KIND_IPV4_OUT, c_mac[i], '0, '0, hdl);
            return;
         end
      end
      for (int i = 0; i < NE; i++) if (!h_ok[i] && slot < 0) slot = i;
      if (slot < 0) begin
         add(KIND_DROP, '0, '0, '0, hdl);
         return;
      end
      h_ok[slot] = 1; h_ip[slot] = hop; h_hdl[slot] = hdl; h_stamp[slot] = stamp_next++;
      for (int i = 0; i < NE; i++) if (r_ok[i] && r_ip[i] == hop) live = 1;
      if (!live) begin
         s = choose_slot(r_ok, r_ip, r_tmr, hop);
         r_ok[s] = 1; r_ip[s] = hop; r_tmr[s] = hold_time;
         add(KIND_ARP_REQ, BCAST_MAC, '0, hop, '0);
      end
   endfunction

   function automatic void resolve_receive(logic [REQ_TDATA_W-1:0] d);
      logic [HDL_W-1:0]   hdl;
      logic [MAC_W-1:0]   dst, src, smac;
      logic [ETYPE_W-1:0] etype;
      logic               ok;
      logic [OPCODE_W-1:0] op;
      logic [IP_W-1:0]    sip, tip;
      int s, best;
      hdl = d[47:32]; dst = d[95:48]; src = d[143:96]; etype = d[159:144]; ok = d[160];
      op = d[176:161]; smac = d[224:177]; sip = d[256:225]; tip = d[288:257];
      if (dst != my_mac && dst != BCAST_MAC) return;
      if (etype == ETYPE_IPV4) begin
         if (ok) add(KIND_DELIVER, '0, '0, '0, hdl);
      end else if (etype == ETYPE_ARP && ok && tip == my_ip) begin
         s = choose_slot(c_ok, c_ip, c_tmr, sip);
         c_ok[s] = 1; c_ip[s] = sip; c_mac[s] = smac; c_tmr[s] = lifetime;
         if (op == ARP_OP_REPLY) begin
            while (burst.size() < MAX_RESULTS) begin
               best = -1;
               for (int i = 0; i < NE; i++)
                  if (h_ok[i] && h_ip[i] == sip && (best < 0 || h_stamp[i] < h_stamp[best]))
                     best = i;
               if (best < 0) break;
               add(KIND_IPV4_OUT, smac, '0, '0, h_hdl[best]);
               h_ok[best] = 0;
            end
         end else if (op == ARP_OP_REQUEST) begin
            add(KIND_ARP_REPLY, src, smac, sip, '0);
         end
      end
   endfunction

   function automatic void age_tables(logic [TMR_W-1:0] ms);
      for (int i = 0; i < NE; i++) begin
         if (c_ok[i]) begin
            c_tmr[i] = (c_tmr[i] > ms) ? c_tmr[i] - ms : '0;
            if (c_tmr[i] == 0) c_ok[i] = 0;
         end
         if (r_ok[i]) begin
            r_tmr[i] = (r_tmr[i] > ms) ? r_tmr[i] - ms : '0;
            if (r_tmr[i] == 0) r_ok[i] = 0;
         end
      end
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      logic [MAC_W-1:0] a_dmac, a_tmac;
      logic [IP_W-1:0] a_taddr;
      logic [HDL_W-1:0] a_hdl;
      if (reset) begin
         my_mac = '0; my_ip = '0; lifetime = LIFETIME_RESET; hold_time = HOLD_RESET;
         for (int i = 0; i < NE; i++) begin
            c_ok[i] = 0; r_ok[i] = 0; h_ok[i] = 0;
         end
         stamp_next = 0;
         awaited_q.delete();
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_MAC:    my_mac = csr_wdata;
               CSR_OWN_IP:     my_ip = csr_wdata[IP_W-1:0];
               CSR_CACHE_LIFE: lifetime = csr_wdata[TMR_W-1:0];
               CSR_REQ_HOLD:   hold_time = csr_wdata[TMR_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            a_dmac = rsp_tdata[47:0]; a_tmac = rsp_tdata[95:48];
            a_taddr = rsp_tdata[127:96]; a_hdl = rsp_tdata[143:128];
            if (awaited_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result kind=%0d dmac=%h tmac=%h addr=%h hdl=%h",
                           $realtime, rsp_tuser, a_dmac, a_tmac, a_taddr, a_hdl);
            end else begin
               e = awaited_q[0];
               awaited_q.delete(0);
               if (rsp_tuser != e.kind || a_dmac != e.dmac || a_tmac != e.tmac ||
                   a_taddr != e.taddr || a_hdl != e.hdl || rsp_tlast != e.last) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected kind=%0d dmac=%h tmac=%h addr=%h hdl=%h last=%b",
                              e.kind, e.dmac, e.tmac, e.taddr, e.hdl, e.last);
                     $display("   actual   kind=%0d dmac=%h tmac=%h addr=%h hdl=%h last=%b",
                              rsp_tuser, a_dmac, a_tmac, a_taddr, a_hdl, rsp_tlast);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            burst.delete();
            case (req_tuser)
               CMD_SEND: resolve_send(req_tdata[31:0], req_tdata[47:32]);
               CMD_RECV: resolve_receive(req_tdata);
               CMD_TICK: age_tables(req_tdata[308:289]);
               default: ;
            endcase
            if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
            foreach (burst[i]) awaited_q.insert(awaited_q.size(), burst[i]);
         end
      end
      results_pending = awaited_q.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top of the ARP resolution cache: clock, reset, stimulus and verdict.
module tb_top;
   import arc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [MAC_W-1:0]       csr_wdata = '0;

   int fail_count;
   int results_pending;

   // Idling control: gaps_on enables random bursts on both sides; a change of
   // long_hold_req asks the result side for one long stall.
   bit gaps_on = 1'b1;
   int long_hold_req = 0;
   int idle_cycles = 0;

   // All hops that the well-formed traffic uses live in one small subnet, so that
   // sends, replies and requests keep meeting each other; 24 hops overfill the
   // 16-entry tables and force evictions.
   localparam logic [IP_W-1:0] HOP_BASE = 32'h0A00_0100;
   localparam int HOP_COUNT = 24;
   localparam int CFG_SETTLE = 400;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      cmd_type             cmd;
      logic [IP_W-1:0]     hop;
      logic [HDL_W-1:0]    hdl;
      logic [MAC_W-1:0]    dst, src;
      logic [ETYPE_W-1:0]  etype;
      logic                ok;
      logic [OPCODE_W-1:0] op;
      logic [MAC_W-1:0]    smac;
      logic [IP_W-1:0]     sip, tip;
      logic [TMR_W-1:0]    ms;
   } txn_type;

   logic [MAC_W-1:0] cur_mac;
   logic [IP_W-1:0]  cur_ip;

   arp_resolver_with_timed_cache_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   arp_resolver_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .results_pending(results_pending)
   );

   always #6 clock = ~clock;

   // Result side: random stalls, plus one long stall on request that lets the block
   // fill its result path and refuse new transactions.
   always @(negedge clock) begin : result_side
      int stall_left;
      int long_left;
      int seen_req;
      if (reset) begin
         stall_left = 0; long_left = 0; seen_req = 0;
         rsp_tready = 1'b0;
      end else begin
         if (long_hold_req != seen_req) begin
            seen_req = long_hold_req;
            long_left = 300;
         end
         if (long_left > 0) begin
            long_left--;
            rsp_tready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("** arp_resolver_with_timed_cache_core: FAILED **");
         $finish;
      end
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic [IP_W-1:0] pool_hop();
      return HOP_BASE + IP_W'($urandom_range(0, HOP_COUNT - 1));
   endfunction

   // Sender side: one transaction, preceded now and then by an idle burst.
   task automatic issue(input txn_type t);
      if (gaps_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock) req_tvalid = 1'b0;
      @(negedge clock);
      req_tuser = t.cmd;
      req_tdata = {3'b000, t.ms, t.tip, t.sip, t.smac, t.op, t.ok, t.etype,
                   t.src, t.dst, t.hdl, t.hop};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Register writes happen only once every expected result is out and the block
   // has had time to finish any work that causes no result.
   task automatic quiesce();
      @(negedge clock) req_tvalid = 1'b0;
      wait (results_pending == 0);
      repeat (CFG_SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [MAC_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                            input logic [TMR_W-1:0] life, input logic [TMR_W-1:0] hold);
      quiesce();
      write_reg(CSR_OWN_MAC, mac);
      write_reg(CSR_OWN_IP, {16'h0, ip});
      write_reg(CSR_CACHE_LIFE, {28'h0, life});
      write_reg(CSR_REQ_HOLD, {28'h0, hold});
      cur_mac = mac;
      cur_ip = ip;
   endtask

   function automatic txn_type blank();
      txn_type t;
      t.cmd = CMD_NONE; t.hop = '0; t.hdl = '0; t.dst = '0; t.src = '0; t.etype = '0;
      t.ok = 1'b0; t.op = '0; t.smac = '0; t.sip = '0; t.tip = '0; t.ms = '0;
      return t;
   endfunction

   function automatic txn_type mk_send(logic [IP_W-1:0] hop);
      txn_type t;
      t = blank();
      t.cmd = CMD_SEND; t.hop = hop; t.hdl = HDL_W'($urandom());
      return t;
   endfunction

   // A well-formed ARP message from a hop to this interface. The MAC learned for
   // a hop is derived from its address so that relearning is mostly stable.
   function automatic txn_type mk_arp(logic [IP_W-1:0] hop, logic [OPCODE_W-1:0] op);
      txn_type t;
      t = blank();
      t.cmd = CMD_RECV;
      t.dst = ($urandom_range(0, 1) == 0) ? cur_mac : BCAST_MAC;
      t.src = rand_mac();
      t.etype = ETYPE_ARP; t.ok = 1'b1; t.op = op;
      t.smac = ($urandom_range(0, 3) == 0) ? rand_mac() : {16'h0200, hop};
      t.sip = hop; t.tip = cur_ip;
      return t;
   endfunction

   function automatic txn_type mk_ipv4(logic ok);
      txn_type t;
      t = blank();
      t.cmd = CMD_RECV; t.dst = ($urandom_range(0, 1) == 0) ? cur_mac : BCAST_MAC;
      t.src = rand_mac(); t.etype = ETYPE_IPV4; t.ok = ok; t.hdl = HDL_W'($urandom());
      return t;
   endfunction

   function automatic txn_type mk_tick(logic [TMR_W-1:0] ms);
      txn_type t;
      t = blank();
      t.cmd = CMD_TICK; t.ms = ms;
      return t;
   endfunction

   // Every field random, every command including the unused one.
   function automatic txn_type mk_noise();
      txn_type t;
      t.cmd = cmd_type'($urandom_range(0, 3));
      t.hop = $urandom(); t.hdl = HDL_W'($urandom()); t.dst = rand_mac();
      t.src = rand_mac(); t.etype = ETYPE_W'($urandom()); t.ok = 1'($urandom());
      t.op = OPCODE_W'($urandom()); t.smac = rand_mac();
      t.sip = $urandom(); t.tip = $urandom(); t.ms = TMR_W'($urandom());
      return t;
   endfunction

   task automatic random_traffic(input int count, input logic [TMR_W-1:0] tick_max);
      txn_type t;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35)      t = mk_send(pool_hop());
         else if (pick < 58) t = mk_arp(pool_hop(), ARP_OP_REPLY);
         else if (pick < 66) t = mk_arp(pool_hop(), ARP_OP_REQUEST);
         else if (pick < 74) t = mk_ipv4($urandom_range(0, 3) != 0);
         else if (pick < 84) t = mk_tick(TMR_W'($urandom_range(0, tick_max)));
         else if (pick < 86) t = mk_arp(pool_hop(), OPCODE_W'($urandom()));
         else                t = mk_noise();
         issue(t);
      end
   endtask

   initial begin
      txn_type t;
      logic [IP_W-1:0] hop;
      cur_mac = '0;
      cur_ip = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // Phase one: ordinary settings.
      configure(48'h02AA_BBCC_DD01, 32'h0A00_0001, 20'd30000, 20'd5000);

      // Directed part: one pass through every kind of transaction.
      hop = HOP_BASE;
      issue(mk_send(hop));                        // unknown hop: held, request out
      issue(mk_send(hop));                        // request still live: held quietly
      issue(mk_arp(hop, ARP_OP_REPLY));           // learn and flush both, oldest first
      issue(mk_send(hop));                        // cached: framed at once
      issue(mk_ipv4(1'b1));                       // delivered
      issue(mk_ipv4(1'b0));                       // bad payload: nothing
      issue(mk_arp(hop + 1, ARP_OP_REQUEST));     // answered with a reply
      issue(mk_arp(hop + 2, 16'd3));              // unusual opcode: learn only
      issue(mk_arp(hop + 2, 16'hFFFF));
      t = mk_arp(hop + 3, ARP_OP_REQUEST);
      t.tip = cur_ip ^ 32'h1;                     // aimed elsewhere: ignored
      issue(t);
      t = mk_arp(hop + 3, ARP_OP_REQUEST);
      t.ok = 1'b0;                                // unparsed ARP: ignored
      issue(t);
      t = mk_ipv4(1'b1);
      t.dst = 48'h0;                              // foreign destination MAC
      issue(t);
      t = mk_noise();
      t.cmd = CMD_NONE;                           // unused command
      issue(t);
      issue(mk_tick(20'd0));
      issue(mk_send(hop + 1));
      issue(mk_tick(20'hFFFFF));                  // cache and request entries all expire
      issue(mk_send(hop + 1));                    // needs a new request
      // Pending store full: seventeen datagrams to one silent hop.
      for (int i = 0; i < 17; i++) issue(mk_send(hop + 5));
      issue(mk_arp(hop + 5, ARP_OP_REPLY));       // flush sends every held datagram

      random_traffic(100, 20'd3000);

      // Phase two: shortest timers, all-ones addresses; one long receiver stall.
      configure(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 20'd1, 20'd1);
      long_hold_req++;
      random_traffic(120, 20'd2);

      // Phase three: longest timers, all-zero addresses.
      configure(48'h0, 32'h0, 20'hFFFFF, 20'hFFFFF);
      random_traffic(80, 20'hFFFFF);

      // Phase four: ordinary timers again and no idling on either side.
      configure(48'h0200_1234_5678, 32'hC0A8_0101, 20'd2000, 20'd700);
      gaps_on = 1'b0;
      random_traffic(70, 20'd400);

      @(negedge clock) req_tvalid = 1'b0;
      wait (results_pending == 0);
      repeat (CFG_SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("** arp_resolver_with_timed_cache_core: PASSED **");
      else
         $display("** arp_resolver_with_timed_cache_core: FAILED **");
      $finish;
   end

endmodule
